// ----- src/cascaded_resonator_filter_assert.svh -----
// Assertion macros shared by the checker.
// Both sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef CASCADED_RESONATOR_FILTER_ASSERT_SVH
`define CASCADED_RESONATOR_FILTER_ASSERT_SVH

// Next-cycle implication.
`define CRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// A condition that must never hold.
`define CRF_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ----- src/crf_pkg.sv -----
package crf_pkg;

    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 18;
    localparam int COUNT_W  = 5;
    localparam int COEF_FRAC = 16;
    localparam int PROD_W   = SAMPLE_W + COEF_W;
    localparam int ACC_W    = PROD_W + 2;
    localparam int SHIFT_W  = ACC_W - COEF_FRAC;

    localparam logic [COUNT_W-1:0] DEFAULT_STAGES = 5'd4;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7F_FFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h80_0000;

    // Configuration register indexes
    localparam logic [1:0] REG_STAGE_COUNT  = 2'd0;
    localparam logic [1:0] REG_INPUT_GAIN   = 2'd1;
    localparam logic [1:0] REG_FEEDBACK_ONE = 2'd2;
    localparam logic [1:0] REG_FEEDBACK_TWO = 2'd3;

    localparam logic [COEF_W-1:0] INPUT_GAIN_RESET = 18'h1_0000;

    typedef struct packed {
        logic signed [COEF_W-1:0] c1;
        logic signed [COEF_W-1:0] c2;
        logic signed [COEF_W-1:0] c3;
    } crf_coef_t;

    // Sample moving along the chain
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] data;
    } crf_tok_t;

endpackage

// ----- src/crf_cell.sv -----
module crf_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  crf_pkg::crf_coef_t coef,
    input  crf_pkg::crf_tok_t  tok_in,
    output crf_pkg::crf_tok_t  tok_out
);

    logic signed [crf_pkg::SAMPLE_W-1:0] d1_reg, d1_next;
    logic signed [crf_pkg::SAMPLE_W-1:0] d2_reg, d2_next;
    logic                                 mul_valid_reg, mul_valid_next;
    logic signed [crf_pkg::PROD_W-1:0]    p0_reg, p1_reg, p2_reg;
    logic signed [crf_pkg::PROD_W-1:0]    p0_next, p1_next, p2_next;
    crf_pkg::crf_tok_t                    out_reg, out_next;
    logic signed [crf_pkg::ACC_W-1:0]     acc;
    logic signed [crf_pkg::SHIFT_W-1:0]   shifted;
    logic signed [crf_pkg::SAMPLE_W-1:0]  y;

    // Multiply stage
    always_comb
    begin
        mul_valid_next = tok_in.valid & en;
        p0_next = crf_pkg::PROD_W'(coef.c1 * tok_in.data);
        p1_next = crf_pkg::PROD_W'(coef.c2 * d1_reg);
        p2_next = crf_pkg::PROD_W'(coef.c3 * d2_reg);
    end

    // Sum, floor shift and saturate
    always_comb
    begin
        acc = crf_pkg::ACC_W'(p0_reg) + crf_pkg::ACC_W'(p1_reg) - crf_pkg::ACC_W'(p2_reg);
        shifted = acc[crf_pkg::ACC_W-1:crf_pkg::COEF_FRAC];
        if (shifted[crf_pkg::SHIFT_W-1:crf_pkg::SAMPLE_W-1] == '0 ||
            shifted[crf_pkg::SHIFT_W-1:crf_pkg::SAMPLE_W-1] == '1)
        begin
            y = shifted[crf_pkg::SAMPLE_W-1:0];
        end
        else if (shifted[crf_pkg::SHIFT_W-1])
        begin
            y = crf_pkg::SAMPLE_MIN;
        end
        else
        begin
            y = crf_pkg::SAMPLE_MAX;
        end

        d1_next = d1_reg;
        d2_next = d2_reg;
        out_next.valid = mul_valid_reg;
        out_next.data  = out_reg.data;
        if (mul_valid_reg)
        begin
            d2_next = d1_reg;
            d1_next = y;
            out_next.data = y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg        <= '0;
            d2_reg        <= '0;
            mul_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            d1_reg        <= d1_next;
            d2_reg        <= d2_next;
            mul_valid_reg <= mul_valid_next;
            out_reg       <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p0_reg       <= p0_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
    end

    assign tok_out = out_reg;

endmodule

// ----- src/cascaded_resonator_filter.sv -----
// Path: a sample accepted at the input crosses each section in use (N = sections in use),
// passing its multiply register and then its sum/saturate register, then the output register.
// A sample walks the section chain and its result is taken at the output before the next is accepted.
// Reset (rst_n low, asynchronous): all section delays cleared, registers to defaults
// (4 sections, input gain 1.0, feedbacks 0), no output pending.
module cascaded_resonator_filter
#(
    parameter int MAX_STAGES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] sample_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [23:0] sample_out
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [17:0] cfg_data
);

    localparam int N_W   = $clog2(MAX_STAGES + 1);
    localparam int IDX_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

    logic [crf_pkg::COUNT_W-1:0] count_reg, count_next;
    crf_pkg::crf_coef_t          coef_reg, coef_next;
    logic                        busy_reg, busy_next;
    logic                        mvalid_reg, mvalid_next;
    logic [crf_pkg::SAMPLE_W-1:0] mdata_reg, mdata_next;

    logic [crf_pkg::COUNT_W-1:0] count_dflt;
    logic [N_W-1:0]              n_eff;
    logic [IDX_W-1:0]            last_idx;
    logic [MAX_STAGES-1:0]       en;
    crf_pkg::crf_tok_t           tok_in  [MAX_STAGES];
    crf_pkg::crf_tok_t           tok_out [MAX_STAGES];
    logic                        in_xfer, out_xfer;

    assign in_xfer  = s_tvalid & s_tready;
    assign out_xfer = mvalid_reg & m_tready;

    // Configuration writes
    always_comb
    begin
        count_next = count_reg;
        coef_next  = coef_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                crf_pkg::REG_STAGE_COUNT:  count_next  = cfg_data[crf_pkg::COUNT_W-1:0];
                crf_pkg::REG_INPUT_GAIN:   coef_next.c1 = cfg_data;
                crf_pkg::REG_FEEDBACK_ONE: coef_next.c2 = cfg_data;
                crf_pkg::REG_FEEDBACK_TWO: coef_next.c3 = cfg_data;
                default:                   count_next  = count_reg;
            endcase
        end
    end

    // Sections in use: zero means the default, clamp at the chain length
    always_comb
    begin
        count_dflt = (count_reg == '0) ? crf_pkg::DEFAULT_STAGES : count_reg;
        if (32'(count_dflt) > MAX_STAGES)
        begin
            n_eff = N_W'(MAX_STAGES);
        end
        else
        begin
            n_eff = N_W'(count_dflt);
        end
        last_idx = IDX_W'(n_eff - N_W'(1));
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_STAGES; gi++)
        begin : g_cell
            assign en[gi] = (32'(n_eff) > gi);
            if (gi == 0)
            begin : g_head
                assign tok_in[gi].valid = in_xfer;
                assign tok_in[gi].data  = s_tdata;
            end
            else
            begin : g_link
                assign tok_in[gi] = tok_out[gi-1];
            end
            crf_cell u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (en[gi]),
                .coef    (coef_reg),
                .tok_in  (tok_in[gi]),
                .tok_out (tok_out[gi])
            );
        end
    endgenerate

    // Hold one sample in flight; release on output transfer
    always_comb
    begin
        busy_next   = busy_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        if (in_xfer)
        begin
            busy_next = 1'b1;
        end
        if (tok_out[last_idx].valid)
        begin
            mvalid_next = 1'b1;
            mdata_next  = tok_out[last_idx].data;
        end
        else if (out_xfer)
        begin
            mvalid_next = 1'b0;
            busy_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= crf_pkg::DEFAULT_STAGES;
            coef_reg.c1 <= crf_pkg::INPUT_GAIN_RESET;
            coef_reg.c2 <= '0;
            coef_reg.c3 <= '0;
            busy_reg    <= 1'b0;
            mvalid_reg  <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            coef_reg   <= coef_next;
            busy_reg   <= busy_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mdata_reg <= mdata_next;
    end

    assign s_tready = ~busy_reg;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

// ----- src/crf_checker.sv -----
`include "cascaded_resonator_filter_assert.svh"

module crf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // One sample in flight: the input side stays closed while a result waits
    `CRF_ASSERT_NEVER(a_no_overlap, s_tready && m_tvalid, "input open while result pending")

    `CRF_ASSERT_NEXT(a_close_after_in, s_tvalid && s_tready, !s_tready, "input not closed after transfer")

    `CRF_ASSERT_NEXT(a_drop_after_out, m_tvalid && m_tready, !m_tvalid, "result repeated after transfer")

    `CRF_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

endmodule

bind cascaded_resonator_filter crf_checker u_crf_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
